// ===== design/adu_pkg.sv =====
package adu_pkg;

   localparam int IDX_W       = 10;
   localparam int ROOT_W      = 28;
   localparam int ROOT_STAGES = ROOT_W / 2;
   localparam int DIV_STAGES  = 16;

   typedef enum logic {
      OP_APPLY = 1'b0,
      OP_LOAD  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      CSR_DECAY      = 4'd0,
      CSR_STABILIZER = 4'd1,
      CSR_LR         = 4'd2,
      CSR_WDECAY     = 4'd3
   } csr_index_type;

   localparam logic [15:0] RHO_RESET = 16'd62259;
   localparam logic [30:0] EPS_RESET = 31'd17;
   localparam logic [30:0] LR_RESET  = 31'd167772;
   localparam logic [30:0] WD_RESET  = 31'd0;

   typedef logic [30:0]       acc_type;
   typedef logic [ROOT_W-1:0] root_type;

   localparam acc_type ACC_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
      logic             in_range;
      logic             neg;
      logic [31:0]      gmag;
      logic [31:0]      par;
      acc_type          accd;
      acc_type          ag;
      root_type         sa;
      root_type         sb;
      logic [31:0]      delta;
   } side_type;

   typedef struct packed {
      logic [29:0] rem;
      root_type    root;
      logic [55:0] x;
   } root_lane_type;

   typedef struct packed {
      logic        ovf;
      root_type    rem;
      logic [31:0] lo;
      logic [31:0] q;
   } div_lane_type;

   // two result bits of the digit-by-digit square root
   function automatic root_lane_type root_step2(root_lane_type l);
      root_lane_type r;
      logic [31:0]   acc;
      logic [31:0]   trial;
      r = l;
      for (int k = 0; k < 2; k++) begin
         acc   = {r.rem, r.x[55:54]};
         trial = {2'b00, r.root, 2'b01};
         r.x   = {r.x[53:0], 2'b00};
         if (acc >= trial) begin
            r.rem  = 30'(acc - trial);
            r.root = {r.root[ROOT_W-2:0], 1'b1};
         end else begin
            r.rem  = acc[29:0];
            r.root = {r.root[ROOT_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // two quotient bits of restoring division
   function automatic div_lane_type div_step2(div_lane_type l, root_type sb);
      div_lane_type    r;
      logic [ROOT_W:0] acc;
      r = l;
      for (int k = 0; k < 2; k++) begin
         acc  = {r.rem, r.lo[31]};
         r.lo = {r.lo[30:0], 1'b0};
         if (acc >= {1'b0, sb}) begin
            r.rem = ROOT_W'(acc - {1'b0, sb});
            r.q   = {r.q[30:0], 1'b1};
         end else begin
            r.rem = acc[ROOT_W-1:0];
            r.q   = {r.q[30:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== design/adu_blend.sv =====
module adu_blend (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [15:0]               rho,
   input  logic                      valid_in,
   input  adu_pkg::side_type         side_in,
   input  adu_pkg::acc_type          acc_in,
   input  logic [31:0]               mag_in,
   input  logic [adu_pkg::IDX_W-1:0] probe,
   output logic                      valid_out,
   output adu_pkg::side_type         side_out,
   output adu_pkg::acc_type          acc_out,
   output logic                      hit
);

   logic [2:0]        v_ff;
   adu_pkg::side_type side_ff [3];
   logic [63:0]       sq_ff, sq_in;
   adu_pkg::acc_type  acc1_ff;
   logic [46:0]       pa_ff, pa_in;
   logic [56:0]       pb_ff, pb_in;
   adu_pkg::acc_type  res_ff, res_in;
   logic [39:0]       sq;
   logic [16:0]       rho_inv;
   logic [57:0]       sum;
   logic [41:0]       scaled;

   assign sq_in   = 64'(mag_in) * 64'(mag_in);
   assign sq      = sq_ff[63:24];
   assign rho_inv = 17'h1_0000 - 17'(rho);
   assign pa_in   = 47'(rho) * 47'(acc1_ff);
   assign pb_in   = 57'(rho_inv) * 57'(sq);
   assign sum     = 58'(pa_ff) + 58'(pb_ff);
   assign scaled  = sum[57:16];
   assign res_in  = (|scaled[41:31]) ? adu_pkg::ACC_MAX : scaled[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         sq_ff      <= sq_in;
         acc1_ff    <= acc_in;
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         res_ff     <= res_in;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < 3; s++) begin
         if (v_ff[s] && side_ff[s].idx == probe) begin
            hit = 1'b1;
         end
      end
   end

   assign valid_out = v_ff[2];
   assign side_out  = side_ff[2];
   assign acc_out   = res_ff;

endmodule

// ===== design/adu_root.sv =====
module adu_root (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [30:0]               eps,
   input  logic                      valid_in,
   input  adu_pkg::side_type         side_in,
   input  logic [adu_pkg::IDX_W-1:0] probe,
   output logic                      valid_out,
   output adu_pkg::side_type         side_out,
   output logic                      hit
);

   localparam int N = adu_pkg::ROOT_STAGES;

   logic [N-1:0]           v_ff;
   adu_pkg::side_type      side_ff   [N];
   adu_pkg::root_lane_type lane_a_ff [N];
   adu_pkg::root_lane_type lane_b_ff [N];
   adu_pkg::root_lane_type lane_a_in [N];
   adu_pkg::root_lane_type lane_b_in [N];
   adu_pkg::root_lane_type src_a     [N];
   adu_pkg::root_lane_type src_b     [N];

   always_comb begin
      src_a[0].rem  = '0;
      src_a[0].root = '0;
      src_a[0].x    = {32'(side_in.accd) + 32'(eps), 24'b0};
      src_b[0].rem  = '0;
      src_b[0].root = '0;
      src_b[0].x    = {32'(side_in.ag) + 32'(eps), 24'b0};
      for (int s = 1; s < N; s++) begin
         src_a[s] = lane_a_ff[s-1];
         src_b[s] = lane_b_ff[s-1];
      end
      for (int s = 0; s < N; s++) begin
         lane_a_in[s] = adu_pkg::root_step2(src_a[s]);
         lane_b_in[s] = adu_pkg::root_step2(src_b[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < N; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         lane_a_ff <= lane_a_in;
         lane_b_ff <= lane_b_in;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < N; s++) begin
         if (v_ff[s] && side_ff[s].idx == probe) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      side_out    = side_ff[N-1];
      side_out.sa = lane_a_ff[N-1].root;
      side_out.sb = lane_b_ff[N-1].root;
   end

   assign valid_out = v_ff[N-1];

endmodule

// ===== design/adu_div.sv =====
module adu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      valid_in,
   input  adu_pkg::side_type         side_in,
   input  logic [adu_pkg::IDX_W-1:0] probe,
   output logic                      valid_out,
   output adu_pkg::side_type         side_out,
   output logic                      hit
);

   localparam int N = adu_pkg::DIV_STAGES;

   logic                  v_m_ff;
   adu_pkg::side_type     side_m_ff, side_m_in;
   logic [59:0]           num_ff, num_in;
   logic [N-1:0]          v_ff;
   adu_pkg::side_type     side_ff [N];
   adu_pkg::div_lane_type lane_ff [N];
   adu_pkg::div_lane_type lane_in [N];
   adu_pkg::div_lane_type src     [N];
   logic                  v_f_ff;
   adu_pkg::side_type     side_f_ff;
   logic [31:0]           delta_ff, delta_in;
   adu_pkg::div_lane_type last;

   // a zero divisor root counts as one
   always_comb begin
      side_m_in = side_in;
      if (side_in.sb == '0) begin
         side_m_in.sb = adu_pkg::root_type'(1);
      end
   end

   assign num_in = 60'(side_in.gmag) * 60'(side_in.sa);

   always_comb begin
      src[0].ovf = (num_ff[59:32] >= side_m_ff.sb);
      src[0].rem = num_ff[59:32];
      src[0].lo  = num_ff[31:0];
      src[0].q   = '0;
      for (int s = 1; s < N; s++) begin
         src[s] = lane_ff[s-1];
      end
      for (int s = 0; s < N; s++) begin
         lane_in[s] = adu_pkg::div_step2(src[s], (s == 0) ? side_m_ff.sb : side_ff[s-1].sb);
      end
   end

   // saturate the magnitude and apply the gradient sign
   always_comb begin
      last = lane_ff[N-1];
      if (!side_ff[N-1].neg) begin
         delta_in = (last.ovf || last.q[31]) ? 32'h7FFF_FFFF : last.q;
      end else begin
         delta_in = (last.ovf || last.q > 32'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - last.q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_m_ff <= 1'b0;
         v_ff   <= '0;
         v_f_ff <= 1'b0;
      end else if (en) begin
         v_m_ff <= valid_in;
         v_ff   <= {v_ff[N-2:0], v_m_ff};
         v_f_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_m_ff  <= side_m_in;
         num_ff     <= num_in;
         side_ff[0] <= side_m_ff;
         for (int s = 1; s < N; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         lane_ff   <= lane_in;
         side_f_ff <= side_ff[N-1];
         delta_ff  <= delta_in;
      end
   end

   always_comb begin
      hit = (v_m_ff && side_m_ff.idx == probe) || (v_f_ff && side_f_ff.idx == probe);
      for (int s = 0; s < N; s++) begin
         if (v_ff[s] && side_ff[s].idx == probe) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      side_out       = side_f_ff;
      side_out.delta = delta_ff;
   end

   assign valid_out = v_f_ff;

endmodule

// ===== design/adadelta_parameter_update_top.sv =====
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     operation, element_index, value
// rsp_      out        rsp_valid / rsp_stall     element_index_out, new_parameter, delta
// csr_      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One transaction enters per cycle while req_stall is low; rsp_valid comes from the output register.
// The square roots (14 stages) and the divider (18 stages) make up most of the pipeline depth.
// A transaction whose element is still in the pipeline stalls until that element's
// write-back; element memories have one read and one write port and are written at the last stage.
// Reset clears valid bits and configuration registers only; load an element before its first gradient.
// A stalled result is held in an output register plus skid slot; the pipeline freezes
// only when both are full.
module adadelta_parameter_update_top #(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [adu_pkg::IDX_W-1:0] req_element_index,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [adu_pkg::IDX_W-1:0] rsp_element_index_out,
   output logic signed [31:0]        rsp_new_parameter,
   output logic signed [31:0]        rsp_delta,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [3:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int AW = $clog2(NUM_ELEMENTS);

   logic [15:0] rho_ff;
   logic [30:0] eps_ff, lr_ff, wd_ff;
   logic [61:0] ldp_ff, ldp_in;
   logic [30:0] ld_ff, ld_in;

   logic [31:0]      par_mem  [NUM_ELEMENTS];
   adu_pkg::acc_type accg_mem [NUM_ELEMENTS];
   adu_pkg::acc_type accd_mem [NUM_ELEMENTS];
   logic [31:0]      rd_par_ff;
   adu_pkg::acc_type rd_accg_ff, rd_accd_ff;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             wr_en;
   logic [31:0]      wr_par;
   adu_pkg::acc_type wr_accg, wr_accd;

   logic                      en, hit_any, accept;
   logic                      v1_ff;
   adu_pkg::op_type           op1_ff;
   logic [adu_pkg::IDX_W-1:0] idx1_ff;
   logic                      rng1_ff;
   logic [31:0]               val1_ff;
   adu_pkg::side_type         side0;

   logic              v_b1, v_rt, v_dv, v_t;
   adu_pkg::side_type side_b1, side_b1x, side_rt, side_dv, side_t;
   adu_pkg::acc_type  ag_b1, accd_new;
   logic              hit_b1, hit_rt, hit_dv, hit_t;
   logic [31:0]       dm2;

   logic signed [63:0] t1p_ff, t1p_in, t2p_ff, t2p_in;
   logic signed [41:0] diff_ff, diff_in;
   logic [31:0]        newp_ff, newp_in;
   logic [31:0]        par_a_ff;

   logic                      is_load;
   logic [31:0]               fin_par, fin_delta;
   logic                      out_v_ff, skid_v_ff, take;
   logic [adu_pkg::IDX_W-1:0] out_idx_ff, skid_idx_ff;
   logic [31:0]               out_par_ff, skid_par_ff, out_dl_ff, skid_dl_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff <= adu_pkg::RHO_RESET;
         eps_ff <= adu_pkg::EPS_RESET;
         lr_ff  <= adu_pkg::LR_RESET;
         wd_ff  <= adu_pkg::WD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (adu_pkg::csr_index_type'(csr_index))
            adu_pkg::CSR_DECAY:      rho_ff <= csr_wdata[15:0];
            adu_pkg::CSR_STABILIZER: eps_ff <= csr_wdata[30:0];
            adu_pkg::CSR_LR:         lr_ff  <= csr_wdata[30:0];
            adu_pkg::CSR_WDECAY:     wd_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign ldp_in = 62'(lr_ff) * 62'(wd_ff);
   assign ld_in  = (|ldp_ff[61:55]) ? 31'h7FFF_FFFF : ldp_ff[54:24];

   always_ff @(posedge clock) begin
      ldp_ff <= ldp_in;
      ld_ff  <= ld_in;
   end

   // input and hazard check
   assign en        = !skid_v_ff;
   assign hit_any   = (v1_ff && idx1_ff == req_element_index) || hit_b1 || hit_rt ||
                      hit_dv || hit_t;
   assign req_stall = skid_v_ff || hit_any;
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = AW'(req_element_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff  <= adu_pkg::op_type'(req_operation);
         idx1_ff <= req_element_index;
         rng1_ff <= (32'(req_element_index) < 32'(NUM_ELEMENTS));
         val1_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         par_mem[wr_addr] <= wr_par;
      end
      if (en) begin
         rd_par_ff <= par_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         accg_mem[wr_addr] <= wr_accg;
      end
      if (en) begin
         rd_accg_ff <= accg_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         accd_mem[wr_addr] <= wr_accd;
      end
      if (en) begin
         rd_accd_ff <= accd_mem[rd_addr];
      end
   end

   always_comb begin
      side0.op       = op1_ff;
      side0.idx      = idx1_ff;
      side0.in_range = rng1_ff;
      side0.neg      = val1_ff[31];
      side0.gmag     = val1_ff[31] ? 32'(32'd0 - val1_ff) : val1_ff;
      side0.par      = (op1_ff == adu_pkg::OP_LOAD) ? val1_ff : rd_par_ff;
      side0.accd     = rd_accd_ff;
      side0.ag       = '0;
      side0.sa       = '0;
      side0.sb       = '0;
      side0.delta    = '0;
   end

   adu_blend u_blend_grad (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .rho       (rho_ff),
      .valid_in  (v1_ff),
      .side_in   (side0),
      .acc_in    (rd_accg_ff),
      .mag_in    (side0.gmag),
      .probe     (req_element_index),
      .valid_out (v_b1),
      .side_out  (side_b1),
      .acc_out   (ag_b1),
      .hit       (hit_b1)
   );

   always_comb begin
      side_b1x    = side_b1;
      side_b1x.ag = ag_b1;
   end

   adu_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .eps       (eps_ff),
      .valid_in  (v_b1),
      .side_in   (side_b1x),
      .probe     (req_element_index),
      .valid_out (v_rt),
      .side_out  (side_rt),
      .hit       (hit_rt)
   );

   adu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v_rt),
      .side_in   (side_rt),
      .probe     (req_element_index),
      .valid_out (v_dv),
      .side_out  (side_dv),
      .hit       (hit_dv)
   );

   // tail: squared-delta blend next to the parameter update
   assign dm2 = side_dv.delta[31] ? 32'(32'd0 - side_dv.delta) : side_dv.delta;

   adu_blend u_blend_delta (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .rho       (rho_ff),
      .valid_in  (v_dv),
      .side_in   (side_dv),
      .acc_in    (side_dv.accd),
      .mag_in    (dm2),
      .probe     (req_element_index),
      .valid_out (v_t),
      .side_out  (side_t),
      .acc_out   (accd_new),
      .hit       (hit_t)
   );

   assign t1p_in  = 64'($signed({1'b0, lr_ff})) * 64'($signed(side_dv.delta));
   assign t2p_in  = 64'($signed({1'b0, ld_ff})) * 64'($signed(side_dv.par));
   assign diff_in = 42'($signed(par_a_ff)) - 42'(t1p_ff >>> 24) - 42'(t2p_ff >>> 24);

   always_comb begin
      if (diff_ff > $signed(42'h0_7FFF_FFFF)) begin
         newp_in = 32'h7FFF_FFFF;
      end else if (diff_ff < $signed(-42'sh0_8000_0000)) begin
         newp_in = 32'h8000_0000;
      end else begin
         newp_in = diff_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1p_ff   <= t1p_in;
         t2p_ff   <= t2p_in;
         par_a_ff <= side_dv.par;
         diff_ff  <= diff_in;
         newp_ff  <= newp_in;
      end
   end

   // write-back
   assign is_load   = (side_t.op == adu_pkg::OP_LOAD);
   assign fin_par   = !side_t.in_range ? 32'd0 : (is_load ? side_t.par : newp_ff);
   assign fin_delta = (!side_t.in_range || is_load) ? 32'd0 : side_t.delta;
   assign wr_en     = en && v_t && side_t.in_range;
   assign wr_addr   = AW'(side_t.idx);
   assign wr_par    = fin_par;
   assign wr_accg   = is_load ? '0 : side_t.ag;
   assign wr_accd   = is_load ? '0 : accd_new;

   // output register and skid slot
   assign take = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= en && v_t;
         end
      end else if (!out_v_ff) begin
         out_v_ff <= en && v_t;
      end else if (en && v_t) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_v_ff) begin
         out_idx_ff <= skid_idx_ff;
         out_par_ff <= skid_par_ff;
         out_dl_ff  <= skid_dl_ff;
      end else if (take || !out_v_ff) begin
         out_idx_ff <= side_t.idx;
         out_par_ff <= fin_par;
         out_dl_ff  <= fin_delta;
      end
      if (!take && out_v_ff && !skid_v_ff) begin
         skid_idx_ff <= side_t.idx;
         skid_par_ff <= fin_par;
         skid_dl_ff  <= fin_delta;
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_element_index_out = out_idx_ff;
   assign rsp_new_parameter     = out_par_ff;
   assign rsp_delta             = out_dl_ff;

endmodule
